// ===== design/pfe_pkg.sv =====
package pfe_pkg;

    // Raw command codes as they arrive on the request channel
    localparam logic [2:0] CMD_ARM    = 3'd0;
    localparam logic [2:0] CMD_TICK   = 3'd1;
    localparam logic [2:0] CMD_DELAY  = 3'd2;
    localparam logic [2:0] CMD_BLEND  = 3'd3;
    localparam logic [2:0] CMD_CANCEL = 3'd4;

    // Fade modes
    localparam logic [1:0] MODE_NONE  = 2'd0;
    localparam logic [1:0] MODE_IN    = 2'd1;
    localparam logic [1:0] MODE_OUT   = 2'd2;
    localparam logic [1:0] MODE_XFADE = 2'd3;

    // Status codes reported with every result
    localparam logic [1:0] ST_ARMED = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_IDLE  = 2'd3;

    // Configuration register indexes
    localparam int         CFG_IDX_W  = 2;
    localparam int         CFG_DATA_W = 8;
    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_COLOR  = 2'd1;
    localparam logic [1:0] REG_LENGTH = 2'd2;

    localparam logic [5:0] FULL_LEVEL   = 6'd63;
    localparam logic [7:0] LENGTH_RESET = 8'd64;

    // Blend numerator is at most 63 * 255
    localparam int         NUM_W     = 14;
    // Two quotient bits per divider step
    localparam int         DIV_CNT_W = 3;
    localparam logic [2:0] DIV_STEPS = 3'(NUM_W / 2);

    // Command queue between front and back
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = 1;
    localparam int QCNT_W  = 2;

    typedef enum logic [2:0] {
        OP_ARM,
        OP_TICK,
        OP_DELAY,
        OP_BLEND,
        OP_CANCEL,
        OP_NOP
    } pfe_op_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  elapsed;
        logic [15:0] delay_value;
        logic [5:0]  from_value;
        logic [5:0]  to_value;
    } pfe_req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] step;
        logic       changed;
        logic [5:0] component;
    } pfe_rsp_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       color;
        logic [7:0] length;
    } pfe_cfg_t;

    typedef struct packed {
        pfe_op_t     op;
        logic [7:0]  elapsed;
        logic [15:0] delay_value;
        logic [5:0]  from_value;
        logic [5:0]  to_value;
    } pfe_entry_t;

    typedef struct packed {
        logic       valid;
        pfe_entry_t entry;
    } pfe_q_t;

endpackage

// ===== design/pfe_front.sv =====
module pfe_front
    import pfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  pfe_req_t req,
    output pfe_q_t   head,
    input  logic     pop
);

    pfe_entry_t             entries [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]      count_reg, count_next;
    logic                   push;
    pfe_entry_t             classified;

    // Decode the raw command into an operation
    always_comb
    begin
        classified.elapsed     = req.elapsed;
        classified.delay_value = req.delay_value;
        classified.from_value  = req.from_value;
        classified.to_value    = req.to_value;
        case (req.cmd)
            CMD_ARM:    classified.op = OP_ARM;
            CMD_TICK:   classified.op = OP_TICK;
            CMD_DELAY:  classified.op = OP_DELAY;
            CMD_BLEND:  classified.op = OP_BLEND;
            CMD_CANCEL: classified.op = OP_CANCEL;
            default:    classified.op = OP_NOP;
        endcase
    end

    assign req_ready = (count_reg != QCNT_W'(QDEPTH));
    assign push      = req_valid && req_ready;

    assign head.valid = (count_reg != '0);
    assign head.entry = entries[rd_ptr_reg];

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the accepted beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= classified;
        end
    end

endmodule

// ===== design/pfe_div.sv =====
module pfe_div
    import pfe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [7:0]       den,
    output logic             busy,
    output logic [5:0]       quo
);

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0]     num_reg, num_next;
    logic [7:0]           den_reg, den_next;
    logic [7:0]           rem_reg, rem_next;
    logic [5:0]           quo_reg, quo_next;
    logic [8:0]           trial0, trial1;
    logic                 ge0, ge1;
    logic [7:0]           rem_mid;

    // Two restoring steps per cycle
    always_comb
    begin
        trial0  = {rem_reg, num_reg[NUM_W-1]};
        ge0     = (trial0 >= {1'b0, den_reg});
        rem_mid = ge0 ? 8'(trial0 - {1'b0, den_reg}) : trial0[7:0];
        trial1  = {rem_mid, num_reg[NUM_W-2]};
        ge1     = (trial1 >= {1'b0, den_reg});

        cnt_next = cnt_reg;
        num_next = num_reg;
        den_next = den_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (start)
        begin
            cnt_next = DIV_STEPS;
            num_next = num;
            den_next = den;
            rem_next = '0;
            quo_next = '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            num_next = {num_reg[NUM_W-3:0], 2'b00};
            rem_next = ge1 ? 8'(trial1 - {1'b0, den_reg}) : trial1[7:0];
            quo_next = {quo_reg[3:0], ge0, ge1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy = (cnt_reg != '0);
    assign quo  = quo_reg;

endmodule

// ===== design/pfe_back.sv =====
module pfe_back
    import pfe_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pfe_cfg_t cfg,
    input  pfe_q_t   head,
    output logic     pop,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output pfe_rsp_t rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_DIV
    } state_t;

    state_t           state_reg, state_next;
    logic [7:0]       step_reg, step_next;
    logic             started_reg, started_next;
    logic             running_reg, running_next;
    logic [15:0]      wait_reg, wait_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic             rsp_valid_reg, rsp_valid_next;
    pfe_rsp_t         rsp_reg, rsp_next;

    logic [7:0]       len;
    logic             slot_free;
    logic             div_start;
    logic             div_busy;
    logic [5:0]       div_quo;

    logic             tick_active;
    logic             tick_first;
    logic [7:0]       tick_e;
    logic [7:0]       tick_base;
    logic [7:0]       tick_adv;
    logic [8:0]       tick_sum;
    logic [7:0]       tick_clamped;
    logic [7:0]       tick_step;
    logic             tick_started;
    logic             tick_running;
    logic [15:0]      tick_wait;
    logic             tick_changed;

    logic [7:0]       blend_s;
    logic [7:0]       blend_r;
    logic [5:0]       blend_x;
    logic [5:0]       blend_y;
    logic [NUM_W-1:0] blend_num;

    function automatic logic [1:0] status_of(logic run, logic st, logic [1:0] mode);
        logic [1:0] s;
        if (run)
        begin
            s = (mode == MODE_NONE) ? ST_IDLE : (st ? ST_RUN : ST_ARMED);
        end
        else
        begin
            s = st ? ST_DONE : ST_IDLE;
        end
        return s;
    endfunction

    assign len       = (cfg.length == '0) ? 8'd1 : cfg.length;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    // Work out a tick against the current state
    always_comb
    begin
        tick_active  = running_reg && (cfg.mode != MODE_NONE) && (step_reg < len);
        tick_first   = !started_reg;
        tick_e       = tick_first ? 8'd0 : head.entry.elapsed;
        tick_base    = tick_first ? 8'd0 : step_reg;
        tick_adv     = (wait_reg != '0) ? 8'(tick_e - wait_reg[7:0]) : tick_e;
        tick_sum     = {1'b0, tick_base} + {1'b0, tick_adv};
        tick_clamped = (tick_sum > {1'b0, len}) ? len : tick_sum[7:0];

        tick_step    = step_reg;
        tick_started = started_reg;
        tick_running = running_reg;
        tick_wait    = wait_reg;
        tick_changed = 1'b0;
        if (tick_active)
        begin
            tick_started = 1'b1;
            if ((wait_reg != '0) && (wait_reg > {8'd0, tick_e}))
            begin
                // Delay still pending: use up elapsed time only
                tick_step = tick_base;
                tick_wait = wait_reg - {8'd0, tick_e};
            end
            else
            begin
                tick_wait = '0;
                tick_step = tick_clamped;
                if (tick_first || (tick_clamped != step_reg))
                begin
                    tick_changed = 1'b1;
                    if (tick_clamped == len)
                    begin
                        tick_running = 1'b0;
                    end
                end
            end
        end
    end

    // Form the blend numerator
    always_comb
    begin
        blend_s = (step_reg > len) ? len : step_reg;
        blend_r = len - blend_s;
        blend_x = (cfg.mode == MODE_IN)  ? (cfg.color ? FULL_LEVEL : 6'd0)
                                         : head.entry.from_value;
        blend_y = (cfg.mode == MODE_OUT) ? (cfg.color ? FULL_LEVEL : 6'd0)
                                         : head.entry.to_value;
        if (cfg.mode == MODE_NONE)
        begin
            blend_num = '0;
        end
        else
        begin
            blend_num = NUM_W'({8'd0, blend_x} * {6'd0, blend_r})
                      + NUM_W'({8'd0, blend_y} * {6'd0, blend_s});
        end
    end

    // Sequence one queued operation at a time
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        started_next   = started_reg;
        running_next   = running_reg;
        wait_next      = wait_reg;
        num_next       = num_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        pop            = 1'b0;
        div_start      = 1'b0;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.entry.op == OP_BLEND)
                    begin
                        pop        = 1'b1;
                        num_next   = blend_num;
                        state_next = S_LOAD;
                    end
                    else if (slot_free)
                    begin
                        pop = 1'b1;
                        case (head.entry.op)
                            OP_ARM:
                            begin
                                step_next    = '0;
                                started_next = 1'b0;
                                running_next = 1'b1;
                            end
                            OP_TICK:
                            begin
                                step_next    = tick_step;
                                started_next = tick_started;
                                running_next = tick_running;
                                wait_next    = tick_wait;
                            end
                            OP_DELAY:
                            begin
                                wait_next = head.entry.delay_value;
                            end
                            OP_CANCEL:
                            begin
                                running_next = 1'b0;
                                started_next = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                        rsp_next.status    = status_of(running_next, started_next, cfg.mode);
                        rsp_next.step      = step_next;
                        rsp_next.changed   = (head.entry.op == OP_TICK) && tick_changed;
                        rsp_next.component = '0;
                        rsp_valid_next     = 1'b1;
                    end
                end
            end
            S_LOAD:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy && slot_free)
                begin
                    rsp_next.status    = status_of(running_reg, started_reg, cfg.mode);
                    rsp_next.step      = step_reg;
                    rsp_next.changed   = 1'b0;
                    rsp_next.component = div_quo;
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            started_reg   <= 1'b0;
            running_reg   <= 1'b0;
            wait_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            num_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            started_reg   <= started_next;
            running_reg   <= running_next;
            wait_reg      <= wait_next;
            rsp_valid_reg <= rsp_valid_next;
            num_reg       <= num_next;
            rsp_reg       <= rsp_next;
        end
    end

    pfe_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (len),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== design/palette_fade_engine_top.sv =====
// Path: a request beat is held in the queue, then registered as the response for arm, tick, delay, cancel;
// a blend beat passes the numerator register, divider load, 7 radix-4 steps and the result register.
// Throughput: one non-blend beat per cycle while the response side is ready; a blend beat holds
// the back end until the 7 steps of the single two-bit-per-cycle divider are done.
// Reset (rst_n, async, active low): fade state, queue and response clear at once;
// mode none, end color black, fade length 64. No clearing pass.
module palette_fade_engine_top
    import pfe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  pfe_req_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output pfe_rsp_t              rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pfe_cfg_t cfg_reg, cfg_next;
    pfe_q_t   head;
    logic     pop;

    // Decode configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:   cfg_next.mode   = cfg_data[1:0];
                REG_COLOR:  cfg_next.color  = cfg_data[0];
                REG_LENGTH: cfg_next.length = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_NONE;
            cfg_reg.color  <= 1'b0;
            cfg_reg.length <= LENGTH_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pfe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .head      (head),
        .pop       (pop)
    );

    pfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef NO_ASSERTIONS
    // A full queue is the only reason to stall the request side
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> head.valid)
        else $error("request stalled with empty queue");

    // A step update never carries a blended component
    a_changed_no_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.changed) |-> (rsp.component == 6'd0))
        else $error("changed response carries a component");

    // An armed fade that has not started sits at step zero without change
    a_armed_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status == ST_ARMED)) |-> ((rsp.step == 8'd0) && !rsp.changed))
        else $error("armed status with nonzero step or change");

    // Nothing is popped from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import pfe_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 1_000_000;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS   = 105;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned LONG_HOLD     = 400;
    localparam int unsigned HOLD_AFTER    = 250;
    localparam logic [2:0]  CMD_SPARE     = 3'd7;

    // Fade controller mirror: tracks step, run state and pending delay per beat
    class fade_scoreboard;
        logic [1:0]  mode;
        logic        color;
        logic [7:0]  length;
        logic [7:0]  step;
        bit          started;
        bit          running;
        int unsigned wait_left;
        pfe_rsp_t    expected_q[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned blends_seen;
        int unsigned changes_seen;

        function new();
            mode         = MODE_NONE;
            color        = 1'b0;
            length       = LENGTH_RESET;
            step         = '0;
            started      = 1'b0;
            running      = 1'b0;
            wait_left    = 0;
            errors       = 0;
            checked      = 0;
            blends_seen  = 0;
            changes_seen = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_MODE:   mode   = data[1:0];
                REG_COLOR:  color  = data[0];
                REG_LENGTH: length = data;
                default: ;
            endcase
        endfunction

        // Treat a zero length as one
        function int unsigned eff_length();
            return (length == 0) ? 1 : length;
        endfunction

        function logic [1:0] status_now();
            if (running)
            begin
                if (mode == MODE_NONE)
                    return ST_IDLE;
                return started ? ST_RUN : ST_ARMED;
            end
            return started ? ST_DONE : ST_IDLE;
        endfunction

        // Mix source and target at the current step, clamped to the length
        function logic [5:0] mix(logic [5:0] src, logic [5:0] dst);
            int unsigned len;
            int unsigned s;
            int unsigned r;
            int unsigned a;
            int unsigned b;
            int unsigned full;
            int unsigned num;
            len  = eff_length();
            s    = (step > len) ? len : step;
            r    = len - s;
            a    = src;
            b    = dst;
            full = FULL_LEVEL;
            case (mode)
                MODE_IN:    num = (color ? full * r : 0) + b * s;
                MODE_OUT:   num = a * r + (color ? full * s : 0);
                MODE_XFADE: num = a * r + b * s;
                default:    return '0;
            endcase
            return 6'(num / len);
        endfunction

        // Advance on a tick; return whether the step moved or a first tick after arming took effect
        function bit advance(logic [7:0] elapsed);
            int unsigned len;
            int unsigned e;
            int unsigned cur;
            logic [7:0]  old;
            bit          first;
            len   = eff_length();
            e     = elapsed;
            old   = step;
            first = 1'b0;
            if (!running || mode == MODE_NONE || step >= len)
                return 1'b0;
            cur = step;
            // first tick after arming starts the fade and drops its count
            if (!started)
            begin
                started = 1'b1;
                cur     = 0;
                e       = 0;
                first   = 1'b1;
            end
            // burn off pending delay, overshoot carries into the step
            if (wait_left > 0)
            begin
                if (wait_left > e)
                begin
                    wait_left -= e;
                    step = 8'(cur);
                    return 1'b0;
                end
                cur += e - wait_left;
                wait_left = 0;
            end
            else
            begin
                cur += e;
            end
            if (cur > len)
                cur = len;
            step = 8'(cur);
            if (!first && step == old)
                return 1'b0;
            if (cur == len)
                running = 1'b0;
            return 1'b1;
        endfunction

        function void note_request(pfe_req_t beat);
            pfe_rsp_t want;
            want = '0;
            case (beat.cmd)
                CMD_ARM:
                begin
                    step    = '0;
                    started = 1'b0;
                    running = 1'b1;
                end
                CMD_TICK:   want.changed = advance(beat.elapsed);
                CMD_DELAY:  wait_left = beat.delay_value;
                CMD_BLEND:
                begin
                    want.component = mix(beat.from_value, beat.to_value);
                    blends_seen++;
                end
                CMD_CANCEL:
                begin
                    running = 1'b0;
                    started = 1'b1;
                end
                default: ;
            endcase
            want.status = status_now();
            want.step   = step;
            if (want.changed)
                changes_seen++;
            expected_q.push_back(want);
        endfunction

        task report_mismatch(string what, int got_v, int want_v);
            errors++;
            if (errors <= 40)
                $display("ERROR: response %0d: %s got %0d expected %0d",
                         checked, what, got_v, want_v);
        endtask

        task check_response(pfe_rsp_t got);
            pfe_rsp_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                report_mismatch("unexpected beat, status", got.status, 0);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.step !== want.step)
                report_mismatch("step", got.step, want.step);
            if (got.changed !== want.changed)
                report_mismatch("changed", got.changed, want.changed);
            if (got.component !== want.component)
                report_mismatch("component", got.component, want.component);
        endtask
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    pfe_req_t              req       = '0;
    logic                  rsp_valid;
    logic                  rsp_ready = 1'b0;
    pfe_rsp_t              rsp;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    fade_scoreboard sb = new();
    int unsigned    cycle_count   = 0;
    int unsigned    requests_sent = 0;
    int unsigned    config_count  = 0;
    bit             steady        = 1'b0;

    palette_fade_engine_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles and bail out at the limit
    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

    // Check every response beat
    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(rsp);

    // Mostly short idle stretches, a few long ones
    function automatic int unsigned idle_span();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        if (roll < 93)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Response side: random ready with one long hold-off
    initial
    begin : rsp_side
        int unsigned held;
        int unsigned span;
        bit          long_hold_done;
        long_hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!long_hold_done && sb.checked >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                rsp_ready <= 1'b0;
                held = 0;
                while (held < LONG_HOLD)
                begin
                    @(posedge clk);
                    held++;
                end
            end
            else if ($urandom_range(0, 3) != 0)
            begin
                rsp_ready <= 1'b1;
                span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(1, 6);
                repeat (span) @(posedge clk);
            end
            else
            begin
                rsp_ready <= 1'b0;
                span = idle_span();
                repeat (span) @(posedge clk);
            end
        end
    end

    function automatic pfe_req_t make_beat(logic [2:0] cmd, logic [7:0] elapsed,
                                           logic [15:0] delay, logic [5:0] from_v,
                                           logic [5:0] to_v);
        pfe_req_t beat;
        beat.cmd         = cmd;
        beat.elapsed     = elapsed;
        beat.delay_value = delay;
        beat.from_value  = from_v;
        beat.to_value    = to_v;
        return beat;
    endfunction

    // Random payload, with the unused fields carrying junk too
    function automatic pfe_req_t random_beat(logic [2:0] cmd);
        return make_beat(cmd, 8'($urandom), 16'($urandom), 6'($urandom), 6'($urandom));
    endfunction

    // Offer one request beat and hold it until accepted
    task automatic send_beat(input pfe_req_t beat);
        req       <= beat;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sb.note_request(beat);
        if (beat.cmd <= CMD_CANCEL)
            requests_sent++;
    endtask

    task automatic sender_gap();
        int unsigned span;
        if (steady || $urandom_range(0, 1) == 0)
            return;
        span = idle_span();
        req_valid <= 1'b0;
        repeat (span) @(posedge clk);
    endtask

    task automatic issue(input pfe_req_t beat);
        send_beat(beat);
        sender_gap();
    endtask

    // Drop valid and wait for every outstanding response
    task automatic quiesce();
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_config(input logic [1:0] mode, input logic color,
                               input logic [7:0] length);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MODE;
        cfg_data  <= CFG_DATA_W'(mode);
        @(posedge clk);
        sb.set_reg(REG_MODE, CFG_DATA_W'(mode));
        cfg_index <= REG_COLOR;
        cfg_data  <= CFG_DATA_W'(color);
        @(posedge clk);
        sb.set_reg(REG_COLOR, CFG_DATA_W'(color));
        cfg_index <= REG_LENGTH;
        cfg_data  <= length;
        @(posedge clk);
        sb.set_reg(REG_LENGTH, length);
        cfg_we <= 1'b0;
        config_count++;
    endtask

    task automatic directed_checks();
        // reset settings: no mode, nothing running
        issue(make_beat(CMD_BLEND, 8'd0, 16'd0, 6'd63, 6'd63));
        issue(make_beat(CMD_TICK, 8'd255, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_ARM, 8'd0, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_TICK, 8'd5, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_CANCEL, 8'd0, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_SPARE, 8'hFF, 16'hFFFF, 6'h3F, 6'h3F));

        // fade in from white, short length, finish by clamping
        quiesce();
        load_config(MODE_IN, 1'b1, 8'd4);
        issue(make_beat(CMD_ARM, 8'd0, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_BLEND, 8'd0, 16'd0, 6'd0, 6'd63));
        issue(make_beat(CMD_TICK, 8'd255, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_TICK, 8'd1, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_TICK, 8'd255, 16'd0, 6'd0, 6'd0));

        // delay pending on the first tick, then an exact hit
        issue(make_beat(CMD_DELAY, 8'd0, 16'd3, 6'd0, 6'd0));
        issue(make_beat(CMD_ARM, 8'd0, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_TICK, 8'd0, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_TICK, 8'd3, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_DELAY, 8'd0, 16'hFFFF, 6'd0, 6'd0));
        issue(make_beat(CMD_DELAY, 8'd0, 16'd0, 6'd0, 6'd0));

        // zero length acts as one
        quiesce();
        load_config(MODE_OUT, 1'b0, 8'd0);
        issue(make_beat(CMD_ARM, 8'd0, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_BLEND, 8'd0, 16'd0, 6'd63, 6'd0));
        issue(make_beat(CMD_TICK, 8'd1, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_TICK, 8'd1, 16'd0, 6'd0, 6'd0));

        // crossfade deep into a long run, then shrink the length under it
        quiesce();
        load_config(MODE_XFADE, 1'b0, 8'd255);
        issue(make_beat(CMD_ARM, 8'd0, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_TICK, 8'd0, 16'd0, 6'd0, 6'd0));
        issue(make_beat(CMD_TICK, 8'd200, 16'd0, 6'd0, 6'd0));
        quiesce();
        load_config(MODE_XFADE, 1'b1, 8'd10);
        issue(make_beat(CMD_BLEND, 8'd0, 16'd0, 6'd10, 6'd63));
        issue(make_beat(CMD_TICK, 8'd1, 16'd0, 6'd0, 6'd0));
    endtask

    function automatic logic [7:0] pick_elapsed(int unsigned len);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return 8'($urandom_range(0, len / 6 + 1));
        if (roll < 9)
            return 8'($urandom_range(0, len));
        return 8'($urandom);
    endfunction

    function automatic logic [15:0] pick_delay();
        if ($urandom_range(0, 3) != 0)
            return 16'($urandom_range(0, 12));
        return 16'($urandom);
    endfunction

    // One arm-and-run sequence with random content, plus some noise
    task automatic run_fade_sequence();
        pfe_req_t    beat;
        int unsigned len;
        int unsigned n;
        int unsigned k;
        int unsigned roll;
        len = sb.eff_length();
        if ($urandom_range(0, 9) < 3)
        begin
            beat = random_beat(CMD_DELAY);
            beat.delay_value = pick_delay();
            issue(beat);
        end
        if ($urandom_range(0, 9) != 0)
            issue(random_beat(CMD_ARM));
        n = $urandom_range(4, 24);
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 50)
            begin
                beat = random_beat(CMD_TICK);
                beat.elapsed = pick_elapsed(len);
            end
            else if (roll < 85)
                beat = random_beat(CMD_BLEND);
            else if (roll < 90)
            begin
                beat = random_beat(CMD_DELAY);
                beat.delay_value = pick_delay();
            end
            else if (roll < 94)
                beat = random_beat(CMD_CANCEL);
            else if (roll < 97)
                beat = random_beat(CMD_ARM);
            else
                beat = random_beat(3'($urandom));
            issue(beat);
        end
    endtask

    initial
    begin : stimulus
        int unsigned phase;
        int unsigned quota;
        logic [1:0]  mode;
        logic [7:0]  length;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        // random phases, each under its own register setting
        quota = requests_sent;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            quiesce();
            mode = ($urandom_range(0, 7) == 0) ? MODE_NONE
                                               : 2'($urandom_range(MODE_IN, MODE_XFADE));
            case (phase)
                0:       length = 8'd1;
                1:       length = 8'd255;
                2:       length = 8'd0;
                default: length = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 16))
                                                              : 8'($urandom_range(1, 255));
            endcase
            load_config(mode, 1'($urandom), length);
            steady = ($urandom_range(0, 3) == 0);
            quota += PHASE_ITEMS;
            while (requests_sent < quota)
                run_fade_sequence();
        end

        quiesce();
        while (sb.expected_q.size() != 0)
            sb.report_mismatch("missing response, status", 0, sb.expected_q.pop_front().status);

        $display("Run covered %0d requests over %0d register settings: %0d blends, %0d step changes.",
                 requests_sent, config_count, sb.blends_seen, sb.changes_seen);
        $display("Checked %0d response beats, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pfe_pkg.sv
design/pfe_front.sv
design/pfe_div.sv
design/pfe_back.sv
design/palette_fade_engine_top.sv
tb/tb.sv
